@@ design/tournament_branch_predictor_macros.svh @@
// ----------------------------------------------------------------------------
// Tournament branch predictor assertion macros
// Shared assertion forms for the predictor's checker.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// clocked assertion, off while reset is low
`define TBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define TBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Payload types, default sizes and the saturating counter helper.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int unsigned PC_W     = 32;
  localparam int unsigned WORD_LSB = 3;
  localparam int unsigned WORD_W   = PC_W - WORD_LSB;
  localparam int unsigned COUNT_W  = 32;

  localparam logic [PC_W-1:0] FALL_THROUGH = 32'd8;
  localparam logic [1:0]      CTR_INIT     = 2'd2;

  localparam int unsigned DEF_CHOOSER_ENTRIES       = 16384;
  localparam int unsigned DEF_GLOBAL_HISTORY_BITS   = 8;
  localparam int unsigned DEF_GLOBAL_PC_BITS        = 6;
  localparam int unsigned DEF_LOCAL_HISTORY_ENTRIES = 8192;
  localparam int unsigned DEF_LOCAL_HISTORY_BITS    = 6;
  localparam int unsigned DEF_LOCAL_TABLE_COUNT     = 8;

  typedef struct packed {
    logic [PC_W-1:0] branch_pc;
    logic [PC_W-1:0] next_pc;
  } tbp_in_t;

  typedef struct packed {
    logic               predicted_taken;
    logic               mispredicted;
    logic               used_local;
    logic [COUNT_W-1:0] branch_total;
    logic [COUNT_W-1:0] mispredict_total;
  } tbp_out_t;

  function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == 2'd3) ? 2'd3 : c + 2'd1;
    end else begin
      r = (c == 2'd0) ? 2'd0 : c - 2'd1;
    end
    return r;
  endfunction

endpackage

@@ design/tbp_mod.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor index reduction
// Remainder of a PC word by a table size: a bit slice for powers of two,
// otherwise a reciprocal multiply and subtract with the operand, the product and the remainder registered in turn.
// ----------------------------------------------------------------------------
module tbp_mod #(
  parameter int unsigned DIVISOR = 256,
  parameter int unsigned IN_W    = 29,
  localparam int unsigned REM_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  value_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

  if (IS_POW2) begin : g_slice
    localparam logic [REM_W-1:0] MASK = REM_W'(DIVISOR - 1);

    logic             done_q;
    logic [REM_W-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    // divisor of one leaves nothing
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= value_i[REM_W-1:0] & MASK;
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    // rounded-up reciprocal with IN_W + log2 fraction bits gives the exact
    // quotient for every IN_W-bit value
    localparam int unsigned SH    = IN_W + REM_W;
    localparam int unsigned MUL_W = IN_W + 2;
    localparam int unsigned P_W   = IN_W + MUL_W;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) /
                                    64'(DIVISOR);
    localparam logic [MUL_W-1:0] MULT_C = RECIP[MUL_W-1:0];
    localparam logic [IN_W-1:0]  DIV_C  = IN_W'(DIVISOR);

    logic             s1_q;
    logic             s2_q;
    logic             done_q;
    logic [IN_W-1:0]  x_q;
    logic [P_W-1:0]   prod_q;
    logic [REM_W-1:0] rem_q;
    logic [IN_W-1:0]  quot;
    logic [IN_W-1:0]  diff;

    always_comb begin
      quot = IN_W'(prod_q >> SH);
      diff = x_q - quot * DIV_C;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        s1_q <= start_i;
        s2_q <= s1_q;
        if (start_i) begin
          done_q <= 1'b0;
        end else if (s2_q) begin
          done_q <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_q <= value_i;
      end
      if (s1_q) begin
        prod_q <= P_W'(x_q) * P_W'(MULT_C);
      end
      if (s2_q) begin
        rem_q <= diff[REM_W-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule

@@ design/tournament_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor
// A result is registered after the index remainders, the chooser, global and
// local counter reads and the counter update; a table size that is not a power
// of two adds the registered remainder steps. One item is in flight at a time:
// a new item is taken only after three reads and two writes to the counter
// memory and any output stall. Reset starts a clearing pass over every counter
// (33280 at default sizes) and local history before the first item.
// ----------------------------------------------------------------------------
module tournament_branch_predictor
  import tbp_pkg::*;
#(
  parameter int unsigned CHOOSER_ENTRIES       = DEF_CHOOSER_ENTRIES,
  parameter int unsigned GLOBAL_HISTORY_BITS   = DEF_GLOBAL_HISTORY_BITS,
  parameter int unsigned GLOBAL_PC_BITS        = DEF_GLOBAL_PC_BITS,
  parameter int unsigned LOCAL_HISTORY_ENTRIES = DEF_LOCAL_HISTORY_ENTRIES,
  parameter int unsigned LOCAL_HISTORY_BITS    = DEF_LOCAL_HISTORY_BITS,
  parameter int unsigned LOCAL_TABLE_COUNT     = DEF_LOCAL_TABLE_COUNT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tbp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tbp_out_t out_data_o
);

  localparam int unsigned GI_W       = GLOBAL_PC_BITS + GLOBAL_HISTORY_BITS;
  localparam int unsigned GLB_DEPTH  = 1 << GI_W;
  localparam int unsigned LOC_DEPTH  = LOCAL_TABLE_COUNT << LOCAL_HISTORY_BITS;
  localparam int unsigned A_DEPTH    = CHOOSER_ENTRIES + GLB_DEPTH + LOC_DEPTH;
  localparam int unsigned AW         = $clog2(A_DEPTH);
  localparam int unsigned A_GLB_BASE = CHOOSER_ENTRIES;
  localparam int unsigned A_LOC_BASE = CHOOSER_ENTRIES + GLB_DEPTH;
  localparam int unsigned CLR_LEN    = (A_DEPTH > LOCAL_HISTORY_ENTRIES) ?
                                       A_DEPTH : LOCAL_HISTORY_ENTRIES;
  localparam int unsigned CLR_W      = $clog2(CLR_LEN);
  localparam int unsigned CI_W       = $clog2(CHOOSER_ENTRIES);
  localparam int unsigned HI_W       = $clog2(LOCAL_HISTORY_ENTRIES);
  localparam int unsigned LT_W       = (LOCAL_TABLE_COUNT > 1) ?
                                       $clog2(LOCAL_TABLE_COUNT) : 1;
  localparam int unsigned LI_W       = LT_W + LOCAL_HISTORY_BITS;
  localparam int unsigned LHB        = LOCAL_HISTORY_BITS;
  localparam int unsigned GHB        = GLOBAL_HISTORY_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CLR_W-1:0]   clr_q;
  logic [GHB-1:0]     gh_q;
  logic [COUNT_W-1:0] bc_q;
  logic [COUNT_W-1:0] mc_q;
  logic               out_valid_q;
  tbp_out_t           out_q;

  tbp_in_t    in_q;
  logic       taken_q;
  logic [1:0] choice_q;
  logic [1:0] gctr_q;
  logic [1:0] choice_new_q;

  // counter memory: chooser, then global counters, then local counters
  logic [1:0]     mem_a [A_DEPTH];
  logic [1:0]     a_rdata_q;
  logic           a_we, a_re;
  logic [AW-1:0]  a_waddr, a_raddr;
  logic [1:0]     a_wdata;

  // local history memory
  logic [LHB-1:0] mem_b [LOCAL_HISTORY_ENTRIES];
  logic [LHB-1:0] b_rdata_q;
  logic           b_we, b_re;
  logic [HI_W-1:0] b_waddr;
  logic [LHB-1:0] b_wdata;

  logic            in_acc;
  logic            ci_done, hi_done, lt_done, mods_done;
  logic [CI_W-1:0] ci;
  logic [HI_W-1:0] hi;
  logic [LT_W-1:0] lt;
  logic [GI_W-1:0] gi;
  logic [LI_W-1:0] li;
  logic [AW-1:0]   a_caddr, a_gaddr, a_laddr;

  logic       use_local;
  logic [1:0] ctr;
  logic       pred;
  logic       wrong;
  logic       out_free;
  logic       commit;
  logic       clr_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  tbp_mod #(.DIVISOR(CHOOSER_ENTRIES), .IN_W(WORD_W)) u_mod_chooser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (in_data_i.branch_pc[PC_W-1:WORD_LSB]),
    .done_o  (ci_done),
    .rem_o   (ci)
  );

  tbp_mod #(.DIVISOR(LOCAL_HISTORY_ENTRIES), .IN_W(WORD_W)) u_mod_lhist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (in_data_i.branch_pc[PC_W-1:WORD_LSB]),
    .done_o  (hi_done),
    .rem_o   (hi)
  );

  tbp_mod #(.DIVISOR(LOCAL_TABLE_COUNT), .IN_W(WORD_W)) u_mod_ltable (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (in_data_i.branch_pc[PC_W-1:WORD_LSB]),
    .done_o  (lt_done),
    .rem_o   (lt)
  );

  assign mods_done = ci_done && hi_done && lt_done;

  always_comb begin
    gi      = {in_q.branch_pc[WORD_LSB +: GLOBAL_PC_BITS], gh_q};
    li      = {lt, b_rdata_q};
    a_caddr = AW'(ci);
    a_gaddr = AW'(A_GLB_BASE) + AW'(gi);
    a_laddr = AW'(A_LOC_BASE) + AW'(li);

    use_local = ~choice_q[1];
    ctr       = use_local ? a_rdata_q : gctr_q;
    pred      = ctr[1];
    wrong     = pred ^ taken_q;
    out_free  = !out_valid_q || out_ready_i;
    commit    = (state_q == S_EXEC) && out_free;
    clr_last  = (clr_q == CLR_W'(CLR_LEN - 1));
  end

  always_comb begin
    state_d = state_q;
    a_we    = 1'b0;
    a_waddr = a_caddr;
    a_wdata = choice_new_q;
    a_re    = 1'b0;
    a_raddr = a_caddr;
    b_we    = 1'b0;
    b_waddr = hi;
    b_wdata = {b_rdata_q[LHB-2:0], taken_q};
    b_re    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        a_we    = ({1'b0, clr_q} < (CLR_W + 1)'(A_DEPTH));
        a_waddr = clr_q[AW-1:0];
        a_wdata = CTR_INIT;
        b_we    = ({1'b0, clr_q} < (CLR_W + 1)'(LOCAL_HISTORY_ENTRIES));
        b_waddr = clr_q[HI_W-1:0];
        b_wdata = '0;
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // first reads once every index is known
        if (mods_done) begin
          a_re    = 1'b1;
          a_raddr = a_caddr;
          b_re    = 1'b1;
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        a_re    = 1'b1;
        a_raddr = a_gaddr;
        state_d = S_RD2;
      end
      S_RD2: begin
        a_re    = 1'b1;
        a_raddr = a_laddr;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // train the chosen counter and its local history
        if (out_free) begin
          a_we    = 1'b1;
          a_waddr = use_local ? a_laddr : a_gaddr;
          a_wdata = sat_move(ctr, taken_q);
          b_we    = use_local;
          state_d = S_WR;
        end
      end
      S_WR: begin
        a_we    = 1'b1;
        a_waddr = a_caddr;
        a_wdata = choice_new_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[a_waddr] <= a_wdata;
    end
    if (a_re) begin
      a_rdata_q <= mem_a[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mem_b[b_waddr] <= b_wdata;
    end
    if (b_re) begin
      b_rdata_q <= mem_b[hi];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      gh_q        <= '0;
      bc_q        <= '0;
      mc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + CLR_W'(1);
      end
      if (commit) begin
        gh_q        <= {gh_q[GHB-2:0], taken_q};
        bc_q        <= bc_q + COUNT_W'(1);
        mc_q        <= mc_q + COUNT_W'(wrong);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q    <= in_data_i;
      taken_q <= (in_data_i.next_pc != (in_data_i.branch_pc + FALL_THROUGH));
    end
    if (state_q == S_RD1) begin
      choice_q <= a_rdata_q;
    end
    if (state_q == S_RD2) begin
      gctr_q <= a_rdata_q;
    end
    if (commit) begin
      // chooser heads for global when global was right or local was wrong
      choice_new_q           <= sat_move(choice_q, use_local == wrong);
      out_q.predicted_taken  <= pred;
      out_q.mispredicted     <= wrong;
      out_q.used_local       <= use_local;
      out_q.branch_total     <= bc_q + COUNT_W'(1);
      out_q.mispredict_total <= mc_q + COUNT_W'(wrong);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/tbp_checker.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor checker
// Port-level assertions on item flow and reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "tournament_branch_predictor_macros.svh"

module tbp_checker
  import tbp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input tbp_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tbp_out_t out_data_o
);

  // one item in flight at a time
  `TBP_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while an item is in flight")

  // a fresh result is only committed in the EXEC step, never while idle
  `TBP_ASSERT(a_result_not_idle, clk_i, rst_ni, $rose(out_valid_o) |-> !in_ready_o, "result appeared while idle")

  `TBP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result dropped or changed")

  // no items move while reset is held across an edge
  `TBP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni && $past(!rst_ni) |-> !out_valid_o && !in_ready_o, "handshake active in reset")

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
